// ----- src/coo_pkg.sv -----
// Shared constants, register indexes and control types of the circle outline overlay.
package coo_pkg;

    // Default geometry of the frame coordinates
    localparam int COORD_BITS_DEF = 13;
    localparam int FRAC_BITS_DEF  = 8;

    // Pixel value width
    localparam int PIX_BITS = 8;

    // Configuration register index width
    localparam int CFG_IDX_BITS = 3;

    // Configuration register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CENTER_COL   = 3'd0,
        REG_CENTER_ROW   = 3'd1,
        REG_RADIUS       = 3'd2,
        REG_MARK_COLOUR  = 3'd3,
        REG_FRAME_WIDTH  = 3'd4,
        REG_FRAME_HEIGHT = 3'd5
    } cfg_reg_t;

    // Reset values of the registers that do not reset to zero
    localparam logic [PIX_BITS-1:0] MARK_COLOUR_RST = 8'd255;
    localparam int                  FRAME_DIM_RST   = 512;

    // Per-pixel qualifiers carried down the pipe next to the data
    typedef struct packed {
        logic in_band;   // row in the band and row + 1 below the frame height, column inside the frame
        logic row_ok;    // radicand of the row test is not negative
        logic col_ok;    // radicand of the column test is not negative
    } coo_flags_t;

endpackage

// ----- src/coo_ifs.sv -----
// Valid/ready channel interfaces: pixel input, pixel output, register write.

interface coo_pix_in_if
    import coo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [PIX_BITS-1:0]   pixel_in;

    modport source (output valid, output pixel_col, output pixel_row, output pixel_in,
                    input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input pixel_in,
                    output ready);
endinterface

interface coo_pix_out_if
    import coo_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] pixel_out;
    logic                on_outline;

    modport source (output valid, output pixel_out, output on_outline, input ready);
    modport sink   (input valid, input pixel_out, input on_outline, output ready);
endinterface

interface coo_cfg_if
    import coo_pkg::*;
#(
    parameter int DATA_BITS = COORD_BITS_DEF + FRAC_BITS_DEF + 1
) ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/coo_cfg.sv -----
// Configuration register bank of the circle outline overlay.
module coo_cfg
    import coo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    coo_cfg_if.sink                                 cfg,
    output logic signed [COORD_BITS+FRAC_BITS:0]    center_col,
    output logic signed [COORD_BITS+FRAC_BITS:0]    center_row,
    output logic        [COORD_BITS+FRAC_BITS-1:0]  radius_px,
    output logic        [PIX_BITS-1:0]              mark_colour,
    output logic        [COORD_BITS:0]              frame_width,
    output logic        [COORD_BITS:0]              frame_height
);

    localparam int CEN_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int RAD_BITS = COORD_BITS + FRAC_BITS;
    localparam int DIM_BITS = COORD_BITS + 1;

    logic signed [CEN_BITS-1:0] center_col_reg;
    logic signed [CEN_BITS-1:0] center_row_reg;
    logic        [RAD_BITS-1:0] radius_reg;
    logic        [PIX_BITS-1:0] mark_colour_reg;
    logic        [DIM_BITS-1:0] frame_width_reg;
    logic        [DIM_BITS-1:0] frame_height_reg;
    logic                       wr_en;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    // Register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg   <= '0;
            center_row_reg   <= '0;
            radius_reg       <= '0;
            mark_colour_reg  <= MARK_COLOUR_RST;
            frame_width_reg  <= DIM_BITS'(FRAME_DIM_RST);
            frame_height_reg <= DIM_BITS'(FRAME_DIM_RST);
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_CENTER_COL:   center_col_reg   <= signed'(cfg.data[CEN_BITS-1:0]);
                REG_CENTER_ROW:   center_row_reg   <= signed'(cfg.data[CEN_BITS-1:0]);
                REG_RADIUS:       radius_reg       <= cfg.data[RAD_BITS-1:0];
                REG_MARK_COLOUR:  mark_colour_reg  <= cfg.data[PIX_BITS-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data[DIM_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data[DIM_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign center_col   = center_col_reg;
    assign center_row   = center_row_reg;
    assign radius_px    = radius_reg;
    assign mark_colour  = mark_colour_reg;
    assign frame_width  = frame_width_reg;
    assign frame_height = frame_height_reg;

endmodule

// ----- src/coo_front.sv -----
// Front pipe: offsets from the center, band bounds, squares and radicands (3 stages).
module coo_front
    import coo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    // incoming beat
    input  logic                                      in_valid,
    input  logic        [COORD_BITS-1:0]              in_col,
    input  logic        [COORD_BITS-1:0]              in_row,
    input  logic        [PIX_BITS-1:0]                in_pix,
    // configuration
    input  logic signed [COORD_BITS+FRAC_BITS:0]      center_col,
    input  logic signed [COORD_BITS+FRAC_BITS:0]      center_row,
    input  logic        [COORD_BITS+FRAC_BITS-1:0]    radius_px,
    input  logic        [COORD_BITS:0]                frame_width,
    input  logic        [COORD_BITS:0]                frame_height,
    // stage 3 outputs
    output logic                                      out_valid,
    output logic        [COORD_BITS-1:0]              out_col,
    output logic        [COORD_BITS-1:0]              out_row,
    output logic        [PIX_BITS-1:0]                out_pix,
    output logic        [2*(COORD_BITS+FRAC_BITS)-1:0] rad_row,
    output logic        [2*(COORD_BITS+FRAC_BITS)-1:0] rad_col,
    output coo_flags_t                                out_flags
);

    localparam int CEN_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int RAD_BITS = COORD_BITS + FRAC_BITS;
    localparam int DIM_BITS = COORD_BITS + 1;
    localparam int D_BITS   = CEN_BITS + 1;          // pixel minus center
    localparam int B_BITS   = CEN_BITS + 2;          // band bound sums
    localparam int Y_BITS   = B_BITS - 1 - FRAC_BITS; // nonnegative band row
    localparam int RR_BITS  = 2 * RAD_BITS;
    localparam int SQ_BITS  = 2 * D_BITS;
    localparam logic [B_BITS-1:0] TWO_FIX = B_BITS'(2 << FRAC_BITS);

    // ---------------- stage 1 ----------------
    logic signed [D_BITS-1:0] row_fix, col_fix, cx_ext, cy_ext;
    logic signed [B_BITS-1:0] cy_b, r_b, band_lo, band_hi;
    logic signed [D_BITS-1:0] d_row_next, d_col_next;
    logic        [Y_BITS-1:0] ymin_next, ymax_next;
    logic                     col_in_next;

    logic                     s1_valid_reg;
    logic [COORD_BITS-1:0]    s1_col_reg, s1_row_reg;
    logic [PIX_BITS-1:0]      s1_pix_reg;
    logic signed [D_BITS-1:0] s1_d_row_reg, s1_d_col_reg;
    logic [Y_BITS-1:0]        s1_ymin_reg, s1_ymax_reg;
    logic                     s1_col_in_reg;

    // Offsets of the pixel from the center, band bounds clamped at zero
    always_comb
    begin
        row_fix     = signed'({2'b00, in_row, {FRAC_BITS{1'b0}}});
        col_fix     = signed'({2'b00, in_col, {FRAC_BITS{1'b0}}});
        cx_ext      = {center_col[CEN_BITS-1], center_col};
        cy_ext      = {center_row[CEN_BITS-1], center_row};
        d_row_next  = row_fix - cy_ext;
        d_col_next  = col_fix - cx_ext;
        cy_b        = {{2{center_row[CEN_BITS-1]}}, center_row};
        r_b         = signed'({3'b000, radius_px});
        band_lo     = cy_b - r_b - signed'(TWO_FIX);
        band_hi     = cy_b + r_b + signed'(TWO_FIX);
        ymin_next   = band_lo[B_BITS-1] ? '0 : band_lo[B_BITS-2:FRAC_BITS];
        ymax_next   = band_hi[B_BITS-1] ? '0 : band_hi[B_BITS-2:FRAC_BITS];
        col_in_next = ({1'b0, in_col} < frame_width);
    end

    // ---------------- stage 2 ----------------
    logic signed [SQ_BITS-1:0] sq_row_full, sq_col_full;
    logic        [RR_BITS-1:0] rr_next;
    logic        [Y_BITS-1:0]  row_y;
    logic                      in_band_next;

    logic                      s2_valid_reg;
    logic [COORD_BITS-1:0]     s2_col_reg, s2_row_reg;
    logic [PIX_BITS-1:0]       s2_pix_reg;
    logic [SQ_BITS-1:0]        s2_sq_row_reg, s2_sq_col_reg;
    logic [RR_BITS-1:0]        s2_rr_reg;
    logic                      s2_in_band_reg;

    // Squares, and the row compared against the band and the frame height
    always_comb
    begin
        sq_row_full  = s1_d_row_reg * s1_d_row_reg;
        sq_col_full  = s1_d_col_reg * s1_d_col_reg;
        rr_next      = radius_px * radius_px;
        row_y        = Y_BITS'(s1_row_reg);
        in_band_next = (row_y >= s1_ymin_reg) && (row_y < s1_ymax_reg)
                    && ((DIM_BITS'(s1_row_reg) + DIM_BITS'(1)) < frame_height)
                    && s1_col_in_reg;
    end

    // ---------------- stage 3 ----------------
    logic signed [SQ_BITS:0] dd_row, dd_col;
    coo_flags_t              flags_next;

    logic                    s3_valid_reg;
    logic [COORD_BITS-1:0]   s3_col_reg, s3_row_reg;
    logic [PIX_BITS-1:0]     s3_pix_reg;
    logic [RR_BITS-1:0]      s3_rad_row_reg, s3_rad_col_reg;
    coo_flags_t              s3_flags_reg;

    // Radicands r*r - d*d; a negative one disables its test
    always_comb
    begin
        dd_row             = signed'({{(SQ_BITS+1-RR_BITS){1'b0}}, s2_rr_reg})
                           - signed'({1'b0, s2_sq_row_reg});
        dd_col             = signed'({{(SQ_BITS+1-RR_BITS){1'b0}}, s2_rr_reg})
                           - signed'({1'b0, s2_sq_col_reg});
        flags_next.in_band = s2_in_band_reg;
        flags_next.row_ok  = !dd_row[SQ_BITS];
        flags_next.col_ok  = !dd_col[SQ_BITS];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_col_reg     <= in_col;
            s1_row_reg     <= in_row;
            s1_pix_reg     <= in_pix;
            s1_d_row_reg   <= d_row_next;
            s1_d_col_reg   <= d_col_next;
            s1_ymin_reg    <= ymin_next;
            s1_ymax_reg    <= ymax_next;
            s1_col_in_reg  <= col_in_next;

            s2_col_reg     <= s1_col_reg;
            s2_row_reg     <= s1_row_reg;
            s2_pix_reg     <= s1_pix_reg;
            s2_sq_row_reg  <= unsigned'(sq_row_full);
            s2_sq_col_reg  <= unsigned'(sq_col_full);
            s2_rr_reg      <= rr_next;
            s2_in_band_reg <= in_band_next;

            s3_col_reg     <= s2_col_reg;
            s3_row_reg     <= s2_row_reg;
            s3_pix_reg     <= s2_pix_reg;
            s3_rad_row_reg <= flags_next.row_ok ? dd_row[RR_BITS-1:0] : '0;
            s3_rad_col_reg <= flags_next.col_ok ? dd_col[RR_BITS-1:0] : '0;
            s3_flags_reg   <= flags_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_col   = s3_col_reg;
    assign out_row   = s3_row_reg;
    assign out_pix   = s3_pix_reg;
    assign rad_row   = s3_rad_row_reg;
    assign rad_col   = s3_rad_col_reg;
    assign out_flags = s3_flags_reg;

endmodule

// ----- src/coo_sqrt.sv -----
// Pipelined truncated integer square root, one result bit per stage.
module coo_sqrt
    import coo_pkg::*;
#(
    parameter int ROOT_BITS = COORD_BITS_DEF + FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [2*ROOT_BITS-1:0]   radicand,
    output logic [ROOT_BITS-1:0]     root
);

    localparam int W = 2 * ROOT_BITS;

    logic [W-1:0]         rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS];

    // Stage k settles root bit ROOT_BITS-1-k
    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_stage
        localparam int B = ROOT_BITS - 1 - k;

        logic [W-1:0]         rem_in;
        logic [ROOT_BITS-1:0] root_in;
        logic [W-1:0]         trial;
        logic                 take;

        if (k == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign trial = (W'(root_in) << (B + 1)) + (W'(1) << (2 * B));
        assign take  = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? (rem_in - trial) : rem_in;
                root_reg[k] <= take ? (root_in | (ROOT_BITS'(1) << B)) : root_in;
            end
        end
    end

    assign root = root_reg[ROOT_BITS-1];

endmodule

// ----- src/circle_outline_overlay_top.sv -----
// Circle outline overlay: marks frame pixels that lie on a circle outline.
//
// Channels: pix_in carries one pixel a beat (column, row, value); pix_out
// returns one beat per input beat, in order, with the pixel value replaced
// by mark_colour when the pixel lies on the outline, and on_outline set.
// cfg writes the registers (0 center column, 1 center row, 2 radius,
// 3 mark color, 4 frame width, 5 frame height); it is always ready. The user
// must see that it is written only while no pixel is in flight; the block
// itself does not enforce this. Throughput: one pixel per cycle while the
// receiver takes every beat. The pipe runs through three front stages for
// offsets, squares and radicands, one stage per root bit in each of the two
// square root pipes, and the output register.
// Reset clears all valid bits and loads the register defaults (center and
// radius 0, mark color 255, frame 512 x 512).
// When the receiver stalls, the whole pipe holds in place and pix_in.ready
// drops; the output register keeps its beat until it is taken.
module circle_outline_overlay_top
    import coo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    coo_pix_in_if.sink    pix_in,
    coo_pix_out_if.source pix_out,
    coo_cfg_if.sink       cfg
);

    localparam int CEN_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int RAD_BITS = COORD_BITS + FRAC_BITS;
    localparam int DIM_BITS = COORD_BITS + 1;
    localparam int RR_BITS  = 2 * RAD_BITS;
    localparam int T_BITS   = CEN_BITS + 2;
    localparam int DEPTH    = RAD_BITS;       // square root stages
    localparam logic [T_BITS-1:0] HALF_FIX = T_BITS'(1 << (FRAC_BITS - 1));

    // Configuration
    logic signed [CEN_BITS-1:0] center_col, center_row;
    logic        [RAD_BITS-1:0] radius_px;
    logic        [PIX_BITS-1:0] mark_colour;
    logic        [DIM_BITS-1:0] frame_width, frame_height;

    coo_cfg #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .center_col   (center_col),
        .center_row   (center_row),
        .radius_px    (radius_px),
        .mark_colour  (mark_colour),
        .frame_width  (frame_width),
        .frame_height (frame_height)
    );

    // Global advance: moves unless the output register holds an untaken beat
    logic out_valid_reg;
    logic en;

    assign en           = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = en;

    // Front pipe
    logic                  f_valid;
    logic [COORD_BITS-1:0] f_col, f_row;
    logic [PIX_BITS-1:0]   f_pix;
    logic [RR_BITS-1:0]    f_rad_row, f_rad_col;
    coo_flags_t            f_flags;

    coo_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (pix_in.valid),
        .in_col       (pix_in.pixel_col),
        .in_row       (pix_in.pixel_row),
        .in_pix       (pix_in.pixel_in),
        .center_col   (center_col),
        .center_row   (center_row),
        .radius_px    (radius_px),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .out_valid    (f_valid),
        .out_col      (f_col),
        .out_row      (f_row),
        .out_pix      (f_pix),
        .rad_row      (f_rad_row),
        .rad_col      (f_rad_col),
        .out_flags    (f_flags)
    );

    // Square roots of both radicands
    logic [RAD_BITS-1:0] s_row, s_col;

    coo_sqrt #(
        .ROOT_BITS (RAD_BITS)
    ) u_sqrt_row (
        .clk      (clk),
        .en       (en),
        .radicand (f_rad_row),
        .root     (s_row)
    );

    coo_sqrt #(
        .ROOT_BITS (RAD_BITS)
    ) u_sqrt_col (
        .clk      (clk),
        .en       (en),
        .radicand (f_rad_col),
        .root     (s_col)
    );

    // Side data travels alongside the root pipes
    logic                  dl_valid_reg [DEPTH];
    logic [COORD_BITS-1:0] dl_col_reg   [DEPTH];
    logic [COORD_BITS-1:0] dl_row_reg   [DEPTH];
    logic [PIX_BITS-1:0]   dl_pix_reg   [DEPTH];
    coo_flags_t            dl_flags_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                dl_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            dl_valid_reg[0] <= f_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                dl_valid_reg[i] <= dl_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_col_reg[0]   <= f_col;
            dl_row_reg[0]   <= f_row;
            dl_pix_reg[0]   <= f_pix;
            dl_flags_reg[0] <= f_flags;
            for (int i = 1; i < DEPTH; i++)
            begin
                dl_col_reg[i]   <= dl_col_reg[i-1];
                dl_row_reg[i]   <= dl_row_reg[i-1];
                dl_pix_reg[i]   <= dl_pix_reg[i-1];
                dl_flags_reg[i] <= dl_flags_reg[i-1];
            end
        end
    end

    // Rounded outline positions c -/+ s, half away from zero, against the pixel.
    // With t = v + 1/2: a match needs t > 0 and floor(t) equal to the coordinate.
    logic                  d_valid;
    logic [COORD_BITS-1:0] d_col, d_row;
    logic [PIX_BITS-1:0]   d_pix;
    coo_flags_t            d_flags;

    logic signed [T_BITS-1:0] cx_t, cy_t, sr_t, sc_t;
    logic signed [T_BITS-1:0] t_row_lo, t_row_hi, t_col_lo, t_col_hi;
    logic                     hit_row_lo, hit_row_hi, hit_col_lo, hit_col_hi;
    logic                     mark_next;

    assign d_valid = dl_valid_reg[DEPTH-1];
    assign d_col   = dl_col_reg[DEPTH-1];
    assign d_row   = dl_row_reg[DEPTH-1];
    assign d_pix   = dl_pix_reg[DEPTH-1];
    assign d_flags = dl_flags_reg[DEPTH-1];

    always_comb
    begin
        cx_t       = {{2{center_col[CEN_BITS-1]}}, center_col};
        cy_t       = {{2{center_row[CEN_BITS-1]}}, center_row};
        sr_t       = signed'({3'b000, s_row});
        sc_t       = signed'({3'b000, s_col});
        t_row_lo   = cx_t - sr_t + signed'(HALF_FIX);
        t_row_hi   = cx_t + sr_t + signed'(HALF_FIX);
        t_col_lo   = cy_t - sc_t + signed'(HALF_FIX);
        t_col_hi   = cy_t + sc_t + signed'(HALF_FIX);
        hit_row_lo = !t_row_lo[T_BITS-1] && (t_row_lo != '0)
                  && (t_row_lo[T_BITS-1:FRAC_BITS] == (T_BITS-FRAC_BITS)'(d_col));
        hit_row_hi = !t_row_hi[T_BITS-1] && (t_row_hi != '0)
                  && (t_row_hi[T_BITS-1:FRAC_BITS] == (T_BITS-FRAC_BITS)'(d_col));
        hit_col_lo = !t_col_lo[T_BITS-1] && (t_col_lo != '0)
                  && (t_col_lo[T_BITS-1:FRAC_BITS] == (T_BITS-FRAC_BITS)'(d_row));
        hit_col_hi = !t_col_hi[T_BITS-1] && (t_col_hi != '0)
                  && (t_col_hi[T_BITS-1:FRAC_BITS] == (T_BITS-FRAC_BITS)'(d_row));
        mark_next  = d_flags.in_band
                  && ((d_flags.row_ok && (hit_row_lo || hit_row_hi))
                   || (d_flags.col_ok && (hit_col_lo || hit_col_hi)));
    end

    // Output register
    logic [PIX_BITS-1:0] pixel_out_reg;
    logic                on_outline_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pixel_out_reg  <= mark_next ? mark_colour : d_pix;
            on_outline_reg <= mark_next;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.pixel_out  = pixel_out_reg;
    assign pix_out.on_outline = on_outline_reg;

endmodule
